// ===== rtl/core/bff_pkg.sv =====
// Shared types, constants and fixed-point helpers for the free-form deformation block.
`timescale 1ns / 1ps
`default_nettype none

package bff_pkg;

  localparam int DefaultMaxPoints = 4;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [16:0] ONE_Q16 = 17'h1_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASIS,
    ST_BINOM,
    ST_MAC,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    REG_POINTS_X = 2'd0,
    REG_POINTS_Y = 2'd1,
    REG_POINTS_Z = 2'd2
  } reg_e;

  typedef struct packed {
    logic init;
    logic step;
    logic binom;
    logic rot;
  } cell_ctrl_t;

  // Q1.30 product, rounded half up.
  function automatic logic [30:0] mul_q30(logic [30:0] a, logic [30:0] b);
    logic [61:0] pr;
    pr = 62'(a) * 62'(b) + 62'h2000_0000;
    return pr[60:30];
  endfunction

  // Round Q.46 accumulator to Q15.16 and clamp to 32 bits.
  function automatic logic [31:0] round_sat(logic [63:0] acc);
    logic [63:0] u;
    logic signed [34:0] q;
    u = acc + 64'h4000_0000_2000_0000;
    q = $signed({1'b0, u[63:30]}) - 35'sh1_0000_0000;
    if (q > 35'sh0_7FFF_FFFF) return 32'h7FFF_FFFF;
    if (q < -35'sh0_8000_0000) return 32'h8000_0000;
    return q[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bff_if.sv =====
// Item and result channel interfaces of the free-form deformation block.
`timescale 1ns / 1ps
`default_nettype none

interface bff_item_if;
  logic              valid;
  logic              ready;
  logic              op;
  logic [5:0]        point_index;
  logic signed [31:0] write_dx;
  logic signed [31:0] write_dy;
  logic signed [31:0] write_dz;
  logic signed [17:0] coord_s;
  logic signed [17:0] coord_t;
  logic signed [17:0] coord_u;

  modport source (output valid, op, point_index, write_dx, write_dy, write_dz,
                  coord_s, coord_t, coord_u, input ready);
  modport sink (input valid, op, point_index, write_dx, write_dy, write_dz,
                coord_s, coord_t, coord_u, output ready);
endinterface

interface bff_result_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] deform_x;
  logic signed [31:0] deform_y;
  logic signed [31:0] deform_z;
  logic              inside_res;

  modport source (output valid, deform_x, deform_y, deform_z, inside_res, input ready);
  modport sink (input valid, deform_x, deform_y, deform_z, inside_res, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bernstein_free_form_deformation.sv =====
// Top level of the trivariate Bernstein free-form deformation block.
//
// Usage: item_i carries writes (op 0: store one control point displacement
// at point_index) and evaluations (op 1: coordinates s,t,u in Q1.16).
// Each evaluation gives one item on result_o; writes give none.
// points_x/y/z are set through cfg_we_i/cfg_idx_i/cfg_data_i; the user
// must do so only while idle, as the block does not enforce it.
// An evaluation outside the unit box goes from idle to the done state
// and from there into the output register. Inside, it runs MP-1 basis
// steps in the cell rows, one binomial scaling, then one lattice entry
// per cycle over all active points through the lattice store and the
// four-stage multiply-accumulate pipeline.
// One item is in work at a time; item_i.ready is high only when idle.
// A finished result waits in the output register while the receiver
// stalls; the next item is taken meanwhile and its result waits for it.
// Reset clears all lattice valid bits (entries read as zero), sets all
// point counts to 4 and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module bernstein_free_form_deformation import bff_pkg::*; #(
  parameter int MAX_POINTS_PER_AXIS = DefaultMaxPoints
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  bff_item_if.sink    item_i,
  bff_result_if.source result_o,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [2:0] cfg_data_i
);

  localparam int MP    = MAX_POINTS_PER_AXIS;
  localparam int PB    = $clog2(MP + 1);
  localparam int DEPTH = MP * MP * MP;
  localparam int SD    = (DEPTH < 64) ? DEPTH : 64;
  localparam int AW    = $clog2(SD);
  localparam int CW    = $clog2(DEPTH + 1);

  state_e state_q, state_d;

  logic [2:0]    pts_x_q, pts_y_q, pts_z_q;
  logic [PB-1:0] px, py, pz;
  logic [CW-1:0] total;

  logic [PB-1:0] j_q, xc_q, yc_q;
  logic [CW-1:0] cnt_q;
  logic [16:0]   c_s_q, c_t_q, c_u_q;
  logic          zero_q;

  logic          accept, in_box, acc_write, acc_eval, x_wrap, y_wrap, issue;
  cell_ctrl_t    ctrl_x, ctrl_y, ctrl_z;
  logic [30:0]   bx, by, bz;

  logic [95:0]   mem [SD];
  logic [SD-1:0] vld_q;
  logic [AW-1:0] wr_addr, rd_addr;

  logic          v1_q, v2_q, v3_q, hit_q;
  logic [30:0]   bxy_q, bz1_q, w_q;
  logic [95:0]   rd_q, d_q;
  logic signed [63:0] prod_q [3];
  logic [63:0]   acc_q [3];

  logic          out_valid_q, load_out;
  logic [31:0]   out_x_q, out_y_q, out_z_q;
  logic          out_in_q;

  function automatic logic [PB-1:0] eff(logic [2:0] r);
    if (r == 3'd0) return PB'(1);
    if ({1'b0, r} > 4'(MP)) return PB'(MP);
    return PB'(r);
  endfunction

  function automatic logic box_ok(logic signed [17:0] c);
    return !c[17] && (c[16:0] <= ONE_Q16);
  endfunction

  assign px    = eff(pts_x_q);
  assign py    = eff(pts_y_q);
  assign pz    = eff(pts_z_q);
  assign total = CW'(px) * CW'(py) * CW'(pz);

  assign accept    = item_i.valid && item_i.ready;
  assign in_box    = box_ok(item_i.coord_s) && box_ok(item_i.coord_t) &&
                     box_ok(item_i.coord_u);
  assign acc_write = accept && (item_i.op == OP_WRITE) &&
                     ({1'b0, item_i.point_index} < 7'(SD));
  assign acc_eval  = accept && (item_i.op == OP_EVAL);
  assign issue     = (state_q == ST_MAC);
  assign x_wrap    = (xc_q == px - PB'(1));
  assign y_wrap    = (yc_q == py - PB'(1));
  assign wr_addr   = item_i.point_index[AW-1:0];
  assign rd_addr   = cnt_q[AW-1:0];

  // Control: state register and next-state logic.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    item_i.ready = 1'b0;
    load_out     = 1'b0;
    ctrl_x       = '0;
    ctrl_y       = '0;
    ctrl_z       = '0;
    case (state_q)
      ST_IDLE: begin
        item_i.ready = 1'b1;
        if (acc_eval) begin
          ctrl_x.init = in_box;
          ctrl_y.init = in_box;
          ctrl_z.init = in_box;
          state_d     = in_box ? ST_BASIS : ST_DONE;
        end
      end
      ST_BASIS: begin
        ctrl_x.step = 1'b1;
        ctrl_y.step = 1'b1;
        ctrl_z.step = 1'b1;
        if (j_q == PB'(MP - 2)) state_d = ST_BINOM;
      end
      ST_BINOM: begin
        ctrl_x.binom = 1'b1;
        ctrl_y.binom = 1'b1;
        ctrl_z.binom = 1'b1;
        state_d      = ST_MAC;
      end
      ST_MAC: begin
        ctrl_x.rot = 1'b1;
        ctrl_y.rot = x_wrap;
        ctrl_z.rot = x_wrap && y_wrap;
        if (cnt_q == total - CW'(1)) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!v1_q && !v2_q && !v3_q) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || result_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pts_x_q <= 3'd4;
      pts_y_q <= 3'd4;
      pts_z_q <= 3'd4;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_POINTS_X: pts_x_q <= cfg_data_i;
        REG_POINTS_Y: pts_y_q <= cfg_data_i;
        REG_POINTS_Z: pts_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencing counters and captured coordinates.
  always_ff @(posedge clk_i) begin
    if (acc_eval) begin
      c_s_q  <= item_i.coord_s[16:0];
      c_t_q  <= item_i.coord_t[16:0];
      c_u_q  <= item_i.coord_u[16:0];
      zero_q <= !in_box;
      j_q    <= '0;
    end
    if (state_q == ST_BASIS) j_q <= j_q + PB'(1);
    if (state_q == ST_BINOM) begin
      cnt_q <= '0;
      xc_q  <= '0;
      yc_q  <= '0;
    end
    if (issue) begin
      cnt_q <= cnt_q + CW'(1);
      xc_q  <= x_wrap ? '0 : xc_q + PB'(1);
      if (x_wrap) yc_q <= y_wrap ? '0 : yc_q + PB'(1);
    end
  end

  bff_axis #(.MP(MP)) u_axis_x (
    .clk_i (clk_i), .ctrl_i (ctrl_x), .step_idx_i (j_q), .len_i (px),
    .coord_i (c_s_q), .head_o (bx)
  );
  bff_axis #(.MP(MP)) u_axis_y (
    .clk_i (clk_i), .ctrl_i (ctrl_y), .step_idx_i (j_q), .len_i (py),
    .coord_i (c_t_q), .head_o (by)
  );
  bff_axis #(.MP(MP)) u_axis_z (
    .clk_i (clk_i), .ctrl_i (ctrl_z), .step_idx_i (j_q), .len_i (pz),
    .coord_i (c_u_q), .head_o (bz)
  );

  // Lattice store: entries never written read as zero.
  always_ff @(posedge clk_i) begin
    if (acc_write) mem[wr_addr] <= {item_i.write_dz, item_i.write_dy, item_i.write_dx};
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (acc_write) begin
      vld_q[wr_addr] <= 1'b1;
    end
  end

  // Multiply-accumulate pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    bxy_q <= mul_q30(bx, by);
    bz1_q <= bz;
    hit_q <= ({1'b0, cnt_q} < (CW + 1)'(SD)) && vld_q[rd_addr];
    w_q   <= mul_q30(bxy_q, bz1_q);
    d_q   <= hit_q ? rd_q : '0;
    for (int k = 0; k < 3; k++) begin
      prod_q[k] <= $signed({1'b0, w_q}) * $signed(d_q[32*k +: 32]);
    end
    if (state_q == ST_BINOM) begin
      for (int k = 0; k < 3; k++) acc_q[k] <= '0;
    end else if (v3_q) begin
      for (int k = 0; k < 3; k++) acc_q[k] <= acc_q[k] + 64'(prod_q[k]);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_x_q  <= zero_q ? '0 : round_sat(acc_q[0]);
      out_y_q  <= zero_q ? '0 : round_sat(acc_q[1]);
      out_z_q  <= zero_q ? '0 : round_sat(acc_q[2]);
      out_in_q <= !zero_q;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.deform_x   = $signed(out_x_q);
  assign result_o.deform_y   = $signed(out_y_q);
  assign result_o.deform_z   = $signed(out_z_q);
  assign result_o.inside_res = out_in_q;

endmodule

`default_nettype wire

// ===== rtl/core/bff_cell.sv =====
// One basis cell: builds one Bernstein term and shifts it along the axis row.
`timescale 1ns / 1ps
`default_nettype none

module bff_cell import bff_pkg::*; #(
  parameter int MP  = DefaultMaxPoints,
  parameter int IDX = 0,
  localparam int PB = $clog2(MP + 1)
) (
  input  wire logic          clk_i,
  input  wire cell_ctrl_t    ctrl_i,
  input  wire logic [PB-1:0] step_idx_i,
  input  wire logic [PB-1:0] degree_i,
  input  wire logic [30:0]   cq_i,
  input  wire logic [30:0]   cm_i,
  input  wire logic [30:0]   nxt_i,
  output logic [30:0]        val_o
);

  logic [30:0]    p_q, p_d;
  logic [MP-1:0]  coef;
  logic [30+MP:0] prod;

  // Binomial coefficient by Pascal's rule, degree picked at run time.
  function automatic int binom(int n, int k);
    int row [MP];
    for (int i = 0; i < MP; i++) row[i] = 0;
    row[0] = 1;
    for (int r = 1; r < MP; r++) begin
      if (r <= n) begin
        for (int i = MP - 1; i > 0; i--) row[i] = row[i] + row[i-1];
      end
    end
    return row[k];
  endfunction

  always_comb begin
    coef = MP'(binom(int'(degree_i), IDX));
    prod = (31 + MP)'(p_q) * (31 + MP)'(coef);
    p_d  = p_q;
    if (ctrl_i.init) begin
      p_d = ONE_Q30;
    end else if (ctrl_i.step) begin
      // first IDX steps by c, then by 1-c up to the degree
      if (step_idx_i < PB'(IDX)) begin
        p_d = mul_q30(p_q, cq_i);
      end else if (step_idx_i < degree_i) begin
        p_d = mul_q30(p_q, cm_i);
      end
    end else if (ctrl_i.binom) begin
      p_d = prod[30:0];
    end else if (ctrl_i.rot) begin
      p_d = nxt_i;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign val_o = p_q;

endmodule

`default_nettype wire

// ===== rtl/core/bff_axis.sv =====
// Row of basis cells for one axis, rotating so the current term sits at the head.
`timescale 1ns / 1ps
`default_nettype none

module bff_axis import bff_pkg::*; #(
  parameter int MP = DefaultMaxPoints,
  localparam int PB = $clog2(MP + 1)
) (
  input  wire logic          clk_i,
  input  wire cell_ctrl_t    ctrl_i,
  input  wire logic [PB-1:0] step_idx_i,
  input  wire logic [PB-1:0] len_i,
  input  wire logic [16:0]   coord_i,
  output logic [30:0]        head_o
);

  logic [30:0]   cq, cm;
  logic [PB-1:0] degree;
  logic [30:0]   val [MP];
  logic [30:0]   nxt [MP];

  assign cq     = {coord_i, 14'b0};
  assign cm     = ONE_Q30 - cq;
  assign degree = len_i - PB'(1);

  for (genvar k = 0; k < MP; k++) begin : g_cell
    // wrap at the active length so unused cells drop out of the ring
    assign nxt[k] = (PB'(k) == degree) ? val[0] : val[(k + 1) % MP];

    bff_cell #(.MP(MP), .IDX(k)) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl_i),
      .step_idx_i (step_idx_i),
      .degree_i   (degree),
      .cq_i       (cq),
      .cm_i       (cm),
      .nxt_i      (nxt[k]),
      .val_o      (val[k])
    );
  end

  assign head_o = val[0];

endmodule

`default_nettype wire
